// File: design/npsq_pkg.sv
// ----------------------------------------------------------------------------
// npsq_pkg: shared types for the non-preemptive priority schedule queue
// Request and result beats, the stored job entry, codes and a time helper.
// ----------------------------------------------------------------------------
package npsq_pkg;

  // default number of job slots
  localparam int DepthDef = 16;

  // saturation ceiling for all scheduled times
  localparam logic [15:0] TimeMax = 16'hFFFF;

  // operation codes
  typedef enum logic {
    OP_ENQ = 1'b0,
    OP_DEQ = 1'b1
  } op_e;

  // result status codes
  typedef enum logic [1:0] {
    ST_ENQ       = 2'd0,
    ST_DEQ       = 2'd1,
    ST_DEQ_EMPTY = 2'd2,
    ST_ENQ_FULL  = 2'd3
  } status_e;

  // request beat
  typedef struct packed {
    op_e         operation;
    logic [15:0] job_tag;
    logic [7:0]  job_priority;
    logic [15:0] arrival_time;
    logic [15:0] service_time;
  } req_t;

  // result beat
  typedef struct packed {
    status_e     status;
    logic [3:0]  slot;
    logic [15:0] out_tag;
    logic [7:0]  out_priority;
    logic [15:0] start_time;
    logic [15:0] end_time;
    logic [4:0]  occupancy;
  } res_t;

  // one queued job as held in a cell
  typedef struct packed {
    logic [15:0] tag;
    logic [7:0]  prio;
    logic [15:0] service;
    logic [15:0] start_time;
    logic [15:0] end_time;
  } entry_t;

  // 16-bit add that clips at the time ceiling
  function automatic logic [15:0] sat_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[16] ? TimeMax : s[15:0];
  endfunction

endpackage

// File: design/npsq_cell.sv
// ----------------------------------------------------------------------------
// npsq_cell: one job slot of the queue chain
// Holds one entry and loads its right neighbor's entry on a shift.
// ----------------------------------------------------------------------------
module npsq_cell
  import npsq_pkg::*;
(
  input  logic   clk_i,
  input  logic   shift_i,
  input  entry_t ent_i,
  output entry_t ent_o
);

  entry_t ent_q;

  // payload only, no reset needed
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      ent_q <= ent_i;
    end
  end

  assign ent_o = ent_q;

endmodule

// File: design/nonpreemptive_priority_schedule_queue_core.sv
// ----------------------------------------------------------------------------
// nonpreemptive_priority_schedule_queue_core: priority job queue with schedule
// Chain of job cells plus a scan controller that inserts, reschedules and dequeues.
// ----------------------------------------------------------------------------
// Usage:
//   A request beat on req_i is taken at a clock edge where start is high and
//   busy is low. Every request gives exactly one result beat on res_o, marked
//   by done_o for a single cycle; the receiver cannot hold it off.
//   Dequeue, dequeue on empty and enqueue on full: done_o rises the cycle
//   after the request is taken, and busy stays low, so one such request per
//   cycle is possible.
//   Enqueue into a non-full queue: the whole cell chain rotates once through
//   the scan controller, one cell per cycle. busy is high for the whole
//   rotation and falls as done_o is shown; the next request can be taken in
//   that cycle, so no new enqueue is taken while a rotation is under way.
//   Reset clears the job count and the controller; the cell contents are
//   left as they are and are never read before being written.
// ----------------------------------------------------------------------------
module nonpreemptive_priority_schedule_queue_core
  import npsq_pkg::*;
#(
  parameter int DEPTH = DepthDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  req_t req_i,
  output logic done_o,
  output res_t res_o
);

  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SCAN = 2'b10
  } state_e;

  state_e         state_q, state_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic [CW-1:0]  k_q, k_d;
  logic           ins_q, ins_d;
  logic           done_q, done_d;
  req_t           req_q, req_d;
  entry_t         pend_q, pend_d;
  logic [15:0]    last_end_q, last_end_d;
  logic [CW-1:0]  pos_q, pos_d;
  logic [15:0]    istart_q, istart_d;
  logic [15:0]    iend_q, iend_d;
  res_t           res_q, res_d;

  entry_t         ent_w [DEPTH];
  entry_t         tail_w;
  entry_t         head_w;
  entry_t         new_w;
  entry_t         resch_w;
  logic           shift_w;
  logic           accept_w;
  logic           is_live_w;
  logic           at_end_w;
  logic           ins_here_w;
  logic           fin_w;
  logic [15:0]    nstart_w;
  logic [15:0]    pstart_w;

  // cell chain: each cell takes its right neighbor, the last takes the tail
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    entry_t nxt_w;
    if (i == DEPTH - 1) begin : g_tail
      assign nxt_w = tail_w;
    end else begin : g_mid
      assign nxt_w = ent_w[i+1];
    end
    npsq_cell u_cell (
      .clk_i  (clk_i),
      .shift_i(shift_w),
      .ent_i  (nxt_w),
      .ent_o  (ent_w[i])
    );
  end

  assign head_w   = ent_w[0];
  assign accept_w = start && (state_q == S_IDLE);

  // scan position relative to the stored jobs
  assign is_live_w = k_q < cnt_q;
  assign at_end_w  = k_q == cnt_q;
  assign fin_w     = (state_q == S_SCAN) && (k_q == CW'(DEPTH - 1));

  // the new job goes in front of the first lower-priority entry past the head
  assign ins_here_w = !ins_q && (at_end_w ||
                      (is_live_w && (k_q != '0) && (head_w.prio < req_q.job_priority)));

  // schedule of the new job
  assign nstart_w = (k_q == '0) ? sat_add(req_q.arrival_time, 16'd1)
                                : sat_add(last_end_q, 16'd1);
  always_comb begin
    new_w            = '0;
    new_w.tag        = req_q.job_tag;
    new_w.prio       = req_q.job_priority;
    new_w.service    = req_q.service_time;
    new_w.start_time = nstart_w;
    new_w.end_time   = sat_add(nstart_w, req_q.service_time);
  end

  // pending entry moved back one place and rescheduled
  assign pstart_w = sat_add(last_end_q, 16'd1);
  always_comb begin
    resch_w            = pend_q;
    resch_w.start_time = pstart_w;
    resch_w.end_time   = sat_add(pstart_w, pend_q.service);
  end

  // controller
  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    k_d        = k_q;
    ins_d      = ins_q;
    req_d      = req_q;
    pend_d     = pend_q;
    last_end_d = last_end_q;
    pos_d      = pos_q;
    istart_d   = istart_q;
    iend_d     = iend_q;
    res_d      = res_q;
    done_d     = 1'b0;
    shift_w    = 1'b0;
    tail_w     = head_w;

    unique case (state_q)
      S_IDLE: begin
        if (accept_w) begin
          res_d = '0;
          if (req_i.operation == OP_DEQ) begin
            done_d = 1'b1;
            if (cnt_q == '0) begin
              res_d.status    = ST_DEQ_EMPTY;
              res_d.occupancy = 5'(cnt_q);
            end else begin
              shift_w            = 1'b1;
              cnt_d              = cnt_q - CW'(1);
              res_d.status       = ST_DEQ;
              res_d.out_tag      = head_w.tag;
              res_d.out_priority = head_w.prio;
              res_d.start_time   = head_w.start_time;
              res_d.end_time     = head_w.end_time;
              res_d.occupancy    = 5'(cnt_d);
            end
          end else if (cnt_q >= CW'(DEPTH)) begin
            done_d          = 1'b1;
            res_d.status    = ST_ENQ_FULL;
            res_d.occupancy = 5'(cnt_q);
          end else begin
            req_d   = req_i;
            k_d     = '0;
            ins_d   = 1'b0;
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        shift_w = 1'b1;
        k_d     = k_q + CW'(1);
        if (ins_here_w) begin
          tail_w     = new_w;
          pend_d     = head_w;
          ins_d      = 1'b1;
          last_end_d = new_w.end_time;
          pos_d      = k_q;
          istart_d   = new_w.start_time;
          iend_d     = new_w.end_time;
        end else if (ins_q && (is_live_w || at_end_w)) begin
          tail_w     = resch_w;
          pend_d     = head_w;
          last_end_d = resch_w.end_time;
        end else if (is_live_w) begin
          last_end_d = head_w.end_time;
        end
        if (fin_w) begin
          state_d            = S_IDLE;
          done_d             = 1'b1;
          cnt_d              = cnt_q + CW'(1);
          res_d              = '0;
          res_d.status       = ST_ENQ;
          res_d.slot         = 4'(pos_d);
          res_d.out_tag      = req_q.job_tag;
          res_d.out_priority = req_q.job_priority;
          res_d.start_time   = istart_d;
          res_d.end_time     = iend_d;
          res_d.occupancy    = 5'(cnt_d);
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      k_q     <= '0;
      ins_q   <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      k_q     <= k_d;
      ins_q   <= ins_d;
      done_q  <= done_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    req_q      <= req_d;
    pend_q     <= pend_d;
    last_end_q <= last_end_d;
    pos_q      <= pos_d;
    istart_q   <= istart_d;
    iend_q     <= iend_d;
    res_q      <= res_d;
  end

  assign busy   = state_q == S_SCAN;
  assign done_o = done_q;
  assign res_o  = res_q;

`ifndef SYNTHESIS
  // job count never passes the number of cells
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(DEPTH))
    else $error("job count above depth");

  // a result beat only follows a request edge or the end of a scan
  a_done_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(accept_w || fin_w))
    else $error("result beat without a cause");

  // every finished scan has placed the new job
  a_ins_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_w |-> (ins_q || ins_here_w))
    else $error("scan ended without insertion");

  // a scan starts from the first cell with nothing placed yet
  a_scan_init: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> (k_q == '0) && !ins_q)
    else $error("scan started in wrong state");
`endif

endmodule
